>>> rtl/kert_pkg.sv
package kert_pkg;

  // operation codes of the kind field
  localparam logic [1:0] KIND_UPSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 7;

  localparam logic [31:0] DEFAULT_LIFETIME = 32'd3600;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] key_high;
    logic [WORD_W-1:0] key_low;
    logic [TIME_W-1:0] seen_time;
    logic [TIME_W-1:0] expiry_time;
    logic [WORD_W-1:0] record_payload;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [WORD_W-1:0]  found_payload;
    logic [TIME_W-1:0]  found_seen;
    logic [TIME_W-1:0]  found_expiry;
    logic [COUNT_W-1:0] removed_count;
  } out_item_t;

  // one stored record, one memory word
  typedef struct packed {
    logic [WORD_W-1:0] key_high;
    logic [WORD_W-1:0] key_low;
    logic [TIME_W-1:0] seen;
    logic [TIME_W-1:0] expiry;
    logic [WORD_W-1:0] body;
  } rec_t;

endpackage

>>> rtl/kert_stream_if.sv
interface kert_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/kert_rec_mem.sv
module kert_rec_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  kert_pkg::rec_t  wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output kert_pkg::rec_t  rd_data
);

  kert_pkg::rec_t mem [DEPTH];
  kert_pkg::rec_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/keyed_expiring_record_table_top.sv
// channel  | dir | payload      | transfer when
// in_chan  | in  | in_item_t    | valid && ready, ready only while idle
// out_chan | out | out_item_t   | valid && ready, one result per item
// cfg      | in  | 32-bit value | cfg_we high, lifetime register
//
// upsert and lookup scan the record memory one entry per cycle from entry 0
// until a hit or the last filled entry; an append is written in S_MISS
// an expire sweep passes S_SW_ISSUE and S_SW_CHK for each kept entry and adds
// S_SW_MOVE for each removed entry; the single read port sets this pace
// synchronous active-low reset clears the entry count and handshake and sets the lifetime to DEFAULT_LIFETIME
// a waiting result holds the reply step but not the next transfer on in_chan
module keyed_expiring_record_table_top #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kert_stream_if.sink           in_chan,
  kert_stream_if.source         out_chan,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata
);
  import kert_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MISS,
    S_SW_ISSUE,
    S_SW_CHK,
    S_SW_MOVE,
    S_REPLY
  } state_t;

  state_t          state_r, state_nxt;
  in_item_t        item_r, item_nxt;
  logic [TIME_W-1:0] exp_r, exp_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]   removed_r, removed_nxt;
  out_item_t       res_r, res_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     lifetime_r;

  logic            wr_en, rd_en;
  logic [IW-1:0]   wr_addr, rd_addr;
  rec_t            wr_data, rd_rec;

  logic [31:0]       life;
  logic [TIME_W:0]   exp_sum;
  logic [CW-1:0]     ptr_inc;
  logic [CW-1:0]     count_dec;
  logic [CW+6:0]     removed_ext;
  logic              key_hit;
  logic              expired;
  logic              out_free;
  rec_t              upsert_rec;

  // record memory
  kert_rec_mem #(
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_rec)
  );

  // default expiry: seen plus lifetime, saturated to the time range
  assign life    = (lifetime_r == '0) ? DEFAULT_LIFETIME : lifetime_r;
  assign exp_sum = {1'b0, in_chan.data.seen_time} + {{(TIME_W + 1 - 32){1'b0}}, life};

  assign ptr_inc     = ptr_r + CW'(1);
  assign count_dec   = count_r - CW'(1);
  assign removed_ext = {7'b0, removed_r};
  assign key_hit     = (rd_rec.key_high == item_r.key_high) &&
                       (rd_rec.key_low == item_r.key_low);
  assign expired     = (rd_rec.expiry != '0) && (rd_rec.expiry <= item_r.now_time);
  assign out_free    = !out_valid_r || out_chan.ready;

  assign upsert_rec.key_high = item_r.key_high;
  assign upsert_rec.key_low  = item_r.key_low;
  assign upsert_rec.seen     = item_r.seen_time;
  assign upsert_rec.expiry   = exp_r;
  assign upsert_rec.body     = item_r.record_payload;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    exp_nxt       = exp_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    removed_nxt   = removed_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r[IW-1:0];
    wr_data       = upsert_rec;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[IW-1:0];

    // output register drains independently
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          item_nxt = in_chan.data;
          res_nxt  = '0;
          ptr_nxt  = '0;
          if (in_chan.data.expiry_time != '0) begin
            exp_nxt = in_chan.data.expiry_time;
          end else if (exp_sum[TIME_W]) begin
            exp_nxt = '1;
          end else begin
            exp_nxt = exp_sum[TIME_W-1:0];
          end
          case (in_chan.data.kind)
            KIND_UPSERT, KIND_LOOKUP: begin
              if (count_r == '0) begin
                state_nxt = S_MISS;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_SCAN;
              end
            end
            KIND_EXPIRE: begin
              removed_nxt = '0;
              state_nxt   = S_SW_ISSUE;
            end
            default: begin
              state_nxt = S_REPLY;
            end
          endcase
        end
      end

      // compare entry ptr_r; unless it hits or is the last, fetch the next one
      S_SCAN: begin
        if (key_hit) begin
          res_nxt.status = ST_OK;
          if (item_r.kind == KIND_UPSERT) begin
            wr_en   = 1'b1;
            wr_addr = ptr_r[IW-1:0];
          end else begin
            res_nxt.found_payload = rd_rec.body;
            res_nxt.found_seen    = rd_rec.seen;
            res_nxt.found_expiry  = rd_rec.expiry;
          end
          state_nxt = S_REPLY;
        end else if (ptr_inc == count_r) begin
          state_nxt = S_MISS;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_inc[IW-1:0];
          ptr_nxt = ptr_inc;
        end
      end

      // key absent: append, reject or report not found
      S_MISS: begin
        if (item_r.kind == KIND_UPSERT) begin
          if (count_r == FULL_CNT) begin
            res_nxt.status = ST_FULL;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = count_r[IW-1:0];
            count_nxt      = count_r + CW'(1);
            res_nxt.status = ST_OK;
          end
        end else begin
          res_nxt.status = ST_MISS;
        end
        state_nxt = S_REPLY;
      end

      S_SW_ISSUE: begin
        if (ptr_r >= count_r) begin
          res_nxt.status        = ST_OK;
          res_nxt.removed_count = removed_ext[6:0];
          state_nxt             = S_REPLY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_r[IW-1:0];
          state_nxt = S_SW_CHK;
        end
      end

      // expired entry: fetch the last one to fill the gap
      S_SW_CHK: begin
        if (expired) begin
          rd_en     = 1'b1;
          rd_addr   = count_dec[IW-1:0];
          state_nxt = S_SW_MOVE;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_SW_ISSUE;
        end
      end

      S_SW_MOVE: begin
        wr_en       = 1'b1;
        wr_addr     = ptr_r[IW-1:0];
        wr_data     = rd_rec;
        count_nxt   = count_dec;
        removed_nxt = removed_r + CW'(1);
        state_nxt   = S_SW_ISSUE;
      end

      S_REPLY: begin
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      lifetime_r  <= DEFAULT_LIFETIME;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        lifetime_r <= cfg_wdata;
      end
    end
    item_r     <= item_nxt;
    exp_r      <= exp_nxt;
    ptr_r      <= ptr_nxt;
    removed_r  <= removed_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // the fill count never passes the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above table size");

  // reads only touch filled entries
  a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CW'(rd_addr) < count_r))
    else $error("read of an unfilled entry");

  // writes go to a filled entry or the append slot
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) <= count_r))
    else $error("write beyond the append slot");

  // each gap fill shrinks the table by one and counts one removal
  a_move_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SW_MOVE) |=>
      (count_r == $past(count_dec)) && (removed_r == $past(removed_r) + CW'(1)))
    else $error("sweep bookkeeping mismatch");

endmodule
